/* hw/rtl/lkl_pkg.sv */
// ----------------------------------------------------------------------------
// lkl_pkg: shared definitions for the LRU keyed limit table
// Field widths, the default table depth and the structs that travel along the
// row of table cells.
// ----------------------------------------------------------------------------
package lkl_pkg;

	localparam int KEY_W             = 31;
	localparam int LIMIT_W           = 31;
	localparam int TABLE_SLOTS_DEF   = 16;

	// One table entry as it sits in a cell and is handed to the previous cell.
	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [LIMIT_W-1:0] limit;
	} lkl_entry_t;

	// Request and table-wide decisions broadcast to every cell.
	typedef struct packed {
		logic               en;
		logic               evict;
		logic               any_hit;
		logic [KEY_W-1:0]   key;
		logic [LIMIT_W-1:0] limit;
	} lkl_ctl_t;

endpackage

/* hw/rtl/lkl_cell.sv */
// ----------------------------------------------------------------------------
// lkl_cell: one slot of the LRU keyed limit table
// Holds one entry, compares it with the request key, and on an update either
// takes the entry of the next cell, takes the new word, or keeps its own.
// ----------------------------------------------------------------------------
module lkl_cell
	import lkl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lkl_ctl_t   ctl,
	input  logic       hit_in,
	output logic       hit_out,
	input  logic       prev_valid,
	input  lkl_entry_t next_entry,
	output lkl_entry_t entry
);

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               my_hit;
	logic               shift;
	logic               append;

	assign my_hit  = valid_q && (key_q == ctl.key);
	assign hit_out = hit_in | my_hit;

	// A valid cell at or after the hit moves forward; on eviction all do.
	assign shift  = ctl.en && valid_q && (hit_out || ctl.evict);
	// The first free cell takes a key that is not yet in the table.
	assign append = ctl.en && !ctl.any_hit && !ctl.evict && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (append) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && next_entry.valid) begin
			key_q   <= next_entry.key;
			limit_q <= next_entry.limit;
		end else if (shift || append) begin
			key_q   <= ctl.key;
			limit_q <= ctl.limit;
		end
	end

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.limit = limit_q;

endmodule

/* hw/rtl/lru_keyed_limit_table_core.sv */
// ----------------------------------------------------------------------------
// lru_keyed_limit_table_core: LRU-ordered table of user keys and limits
// A row of cells, oldest entry at the front, filled from the front. Each
// request refreshes, appends or evicts in a single table update.
// ----------------------------------------------------------------------------
// Timing: the done strobe and evicted are registered and follow an accepted start in the next cycle.
// Throughput: one word per cycle; busy stays low, since the key compare ripples
// along the row of cells and the whole table updates in the accepting cycle.
// Reset: arst_n clears every valid bit and the done strobe; the receiver
// cannot stall, so each result is shown for exactly one cycle.
module lru_keyed_limit_table_core
	import lkl_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [KEY_W-1:0]   user_key,
	input  logic [LIMIT_W-1:0] limit_value,
	output logic               done,
	output logic               evicted
);

	lkl_ctl_t             ctl;
	lkl_entry_t           entries [TABLE_SLOTS];
	logic [TABLE_SLOTS:0] hit_chain;
	logic [TABLE_SLOTS-1:0] valid_vec;
	logic [TABLE_SLOTS-1:0] hit_vec;
	logic                 accept;
	logic                 done_q;
	logic                 evicted_q;

	assign busy         = 1'b0;
	assign accept       = start && !busy;
	assign hit_chain[0] = 1'b0;

	assign ctl.en      = accept;
	assign ctl.any_hit = hit_chain[TABLE_SLOTS];
	assign ctl.evict   = accept && valid_vec[TABLE_SLOTS-1] && !hit_chain[TABLE_SLOTS];
	assign ctl.key     = user_key;
	assign ctl.limit   = limit_value;

	for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
		lkl_entry_t next_entry;
		logic       prev_valid;

		if (g == TABLE_SLOTS - 1) begin : g_last
			assign next_entry = '0;
		end else begin : g_mid
			assign next_entry = entries[g+1];
		end

		if (g == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = entries[g-1].valid;
		end

		lkl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.hit_in     (hit_chain[g]),
			.hit_out    (hit_chain[g+1]),
			.prev_valid (prev_valid),
			.next_entry (next_entry),
			.entry      (entries[g])
		);

		assign valid_vec[g] = entries[g].valid;
		assign hit_vec[g]   = entries[g].valid && (entries[g].key == user_key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			evicted_q <= 1'b0;
		end else begin
			done_q    <= accept;
			evicted_q <= ctl.evict;
		end
	end

	assign done    = done_q;
	assign evicted = evicted_q;

`ifndef NO_ASSERTIONS
	// The valid entries always form one run starting at the front.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec[TABLE_SLOTS-1:1] & ~valid_vec[TABLE_SLOTS-2:0]) == '0)
		else $error("valid entries are not contiguous from the front");

	// A key is stored at most once.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_vec))
		else $error("key present in more than one slot");

	// A result word follows exactly one accepted request.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(accept))
		else $error("done without an accepted request");

	// An eviction is only reported for a request that found the table full.
	assert property (@(posedge clk) disable iff (!arst_n)
		evicted |-> (done && $past(valid_vec[TABLE_SLOTS-1])))
		else $error("eviction reported while the table had room");

	// The number of valid entries never drops and grows by at most one.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == $countones($past(valid_vec)) ||
		$countones(valid_vec) == $countones($past(valid_vec)) + 1)
		else $error("valid entry count changed unexpectedly");
`endif

endmodule
